@@ src/msp_pkg.sv @@
// Package for the motor speed PID controller with setpoint ramp.
// Holds the shared types, item layouts, codes and fixed-point constants.
// Depends on nothing; every file of the block but msp_if imports it.
package msp_pkg;

    localparam logic [15:0]        PWM_PERIOD    = 16'd12500;
    localparam logic [23:0]        TICKS_PER_SEC = 24'd1000;
    localparam logic signed [31:0] SPEED_LIMIT   = 32'sd20000;

    localparam logic [23:0] FILT_K = 24'd419430;
    localparam logic [23:0] DT_K   = 24'd16777;

    localparam logic signed [3:0] RAMP_UP   = 4'sd5;
    localparam logic signed [3:0] RAMP_DOWN = -4'sd5;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET_TARGET = 2'd1,
        OP_START      = 2'd2,
        OP_STOP       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_PROP  = 2'd0,
        REG_INTEG = 2'd1,
        REG_DERIV = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        encoder_position;
        logic signed [31:0] command_value;
    } msp_item_t;

    typedef struct packed {
        logic [15:0]        pwm_duty;
        logic               reverse_dir;
        logic signed [31:0] filtered_error;
        logic signed [31:0] measured_speed;
        logic signed [31:0] ramp_setpoint;
        logic               running;
    } msp_result_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
    } msp_gains_t;

    typedef struct packed {
        logic start;
        logic take;
    } msp_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } msp_sts_t;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } msp_mul_req_t;

endpackage

@@ src/msp_if.sv @@
// Channel interfaces of the motor speed PID controller: command items in,
// result items out, and the gain register write port.
// Depends on nothing.
interface msp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [31:0]        encoder_position;
    logic signed [31:0] command_value;

    modport source (output valid, output opcode, output encoder_position,
                    output command_value, input ready);
    modport sink (input valid, input opcode, input encoder_position,
                  input command_value, output ready);
endinterface

interface msp_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        pwm_duty;
    logic               reverse_dir;
    logic signed [31:0] filtered_error;
    logic signed [31:0] measured_speed;
    logic signed [31:0] ramp_setpoint;
    logic               running;

    modport source (output valid, output pwm_duty, output reverse_dir,
                    output filtered_error, output measured_speed,
                    output ramp_setpoint, output running, input ready);
    modport sink (input valid, input pwm_duty, input reverse_dir,
                  input filtered_error, input measured_speed,
                  input ramp_setpoint, input running, output ready);
endinterface

interface msp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

@@ src/msp_mul.sv @@
// Shared unsigned multiplier of the controller, 32 by 24 bits, with a
// registered product. Depends on msp_pkg.
module msp_mul (
    input  logic                          clk,
    input  msp_pkg::msp_mul_req_t         req,
    output logic [msp_pkg::MUL_P_W-1:0]   prod
);
    import msp_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;
    logic [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(req.a) * MUL_P_W'(req.b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ src/msp_core.sv @@
// Sequencer and datapath of the controller: ramp, speed, filter and PID
// steps, all products taken from the shared multiplier.
// Depends on msp_pkg and on an msp_mul instance beside it.
module msp_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msp_pkg::msp_ctl_t           ctl,
    input  msp_pkg::msp_item_t          item,
    input  msp_pkg::msp_gains_t         gains,
    output msp_pkg::msp_sts_t           sts,
    output msp_pkg::msp_result_t        res,
    output msp_pkg::msp_mul_req_t       mul_req,
    input  logic [msp_pkg::MUL_P_W-1:0] mul_prod
);
    import msp_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_CMD  = 18'h00002,
        S_TGT  = 18'h00004,
        S_SPD  = 18'h00008,
        S_ERR  = 18'h00010,
        S_DIF  = 18'h00020,
        S_MLO  = 18'h00040,
        S_MHI  = 18'h00080,
        S_MFIN = 18'h00100,
        S_MSGN = 18'h00200,
        S_FUPD = 18'h00400,
        S_FABS = 18'h00800,
        S_IADD = 18'h01000,
        S_DABS = 18'h02000,
        S_SUM1 = 18'h04000,
        S_SUM2 = 18'h08000,
        S_DUTY = 18'h10000,
        S_DONE = 18'h20000
    } state_t;

    typedef enum logic [2:0] {
        JOB_FILT = 3'd0,
        JOB_DT   = 3'd1,
        JOB_INT  = 3'd2,
        JOB_P    = 3'd3,
        JOB_D    = 3'd4
    } job_t;

    localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [64:0] Q48_HI = 65'sh7FFF_FFFF_FFFF;
    localparam logic signed [64:0] Q48_LO = -65'sh8000_0000_0000;
    localparam logic [48:0] ROUND_HALF = 49'h80_0000;
    localparam logic signed [63:0] DUTY_CEIL = (64'(PWM_PERIOD) + 64'sd1) <<< 16;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            sat_add64 = s[64] ? INT64_MIN : INT64_MAX;
        end
        else
        begin
            sat_add64 = s[63:0];
        end
    endfunction

    state_t             state_reg, state_next;
    job_t               job_reg, job_next;
    logic [31:0]        last_pos_reg, last_pos_next;
    logic signed [31:0] setpoint_reg, setpoint_next;
    logic signed [31:0] target_reg, target_next;
    logic signed [3:0]  step_reg, step_next;
    logic [1:0]         spin_reg, spin_next;
    logic               stop_pend_reg, stop_pend_next;
    logic               run_reg, run_next;
    logic signed [47:0] filt_reg, filt_next;
    logic signed [47:0] prev_reg, prev_next;
    logic signed [63:0] integ_reg, integ_next;
    logic               rev_reg, rev_next;
    logic [15:0]        duty_reg, duty_next;
    logic signed [31:0] speed_reg, speed_next;

    msp_item_t          item_reg, item_next;
    logic [31:0]        delta_reg, delta_next;
    logic signed [31:0] err_reg, err_next;
    logic [48:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [48:0]        acc_reg, acc_next;
    logic [64:0]        r_reg, r_next;
    logic signed [63:0] val_reg, val_next;
    logic signed [63:0] pterm_reg, pterm_next;
    logic signed [63:0] sum_reg, sum_next;

    logic [23:0]        k_sel;
    logic               q24_mode;
    logic signed [48:0] sub_a, sub_b, d_ab, d_ba;
    logic signed [48:0] filt_ext;
    logic [48:0]        filt_abs;
    logic signed [32:0] ramp_sum, target_ext;
    logic               ramp_hit;
    logic signed [31:0] speed_now;
    logic signed [32:0] err_wide;
    logic signed [31:0] target_clamp;
    logic signed [64:0] filt_sum;
    logic [63:0]        out_abs;
    logic               duty_big;
    logic [15:0]        duty_calc;

    always_comb
    begin
        case (job_reg)
            JOB_FILT: k_sel = FILT_K;
            JOB_DT:   k_sel = DT_K;
            JOB_INT:  k_sel = 24'(gains.integ_gain);
            JOB_P:    k_sel = 24'(gains.prop_gain);
            JOB_D:    k_sel = 24'(gains.deriv_gain);
            default:  k_sel = '0;
        endcase
    end

    assign q24_mode = (job_reg == JOB_FILT) || (job_reg == JOB_DT);

    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            S_SPD:
            begin
                mul_req.a = delta_reg;
                mul_req.b = TICKS_PER_SEC;
            end
            S_MLO:
            begin
                mul_req.a = MUL_A_W'(mag_reg[23:0]);
                mul_req.b = k_sel;
            end
            S_MHI:
            begin
                mul_req.a = MUL_A_W'(mag_reg[48:24]);
                mul_req.b = k_sel;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    assign filt_ext = {filt_reg[47], filt_reg};
    assign filt_abs = filt_reg[47] ? 49'(-filt_ext) : 49'(filt_ext);

    // One pair of subtractors serves both the filter input and the derivative.
    assign sub_a = (state_reg == S_DIF) ? {err_reg[31], err_reg, 16'd0} : filt_ext;
    assign sub_b = (state_reg == S_DIF) ? filt_ext : {prev_reg[47], prev_reg};
    assign d_ab  = sub_a - sub_b;
    assign d_ba  = sub_b - sub_a;

    assign ramp_sum   = {setpoint_reg[31], setpoint_reg} + 33'(step_reg);
    assign target_ext = {target_reg[31], target_reg};
    assign ramp_hit   = step_reg[3] ? (ramp_sum <= target_ext) : (ramp_sum >= target_ext);

    assign speed_now = mul_prod[31:0];
    assign err_wide  = {setpoint_reg[31], setpoint_reg} - {speed_now[31], speed_now};

    always_comb
    begin
        if (item_reg.command_value > SPEED_LIMIT)
        begin
            target_clamp = SPEED_LIMIT;
        end
        else if (item_reg.command_value < -SPEED_LIMIT)
        begin
            target_clamp = -SPEED_LIMIT;
        end
        else
        begin
            target_clamp = item_reg.command_value;
        end
    end

    assign filt_sum = {{17{filt_reg[47]}}, filt_reg} + {val_reg[63], val_reg};

    assign out_abs   = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
    assign duty_big  = (sum_reg >= DUTY_CEIL) || (sum_reg <= -DUTY_CEIL);
    assign duty_calc = duty_big ? PWM_PERIOD : out_abs[31:16];

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        last_pos_next  = last_pos_reg;
        setpoint_next  = setpoint_reg;
        target_next    = target_reg;
        step_next      = step_reg;
        spin_next      = spin_reg;
        stop_pend_next = stop_pend_reg;
        run_next       = run_reg;
        filt_next      = filt_reg;
        prev_next      = prev_reg;
        integ_next     = integ_reg;
        rev_next       = rev_reg;
        duty_next      = duty_reg;
        speed_next     = speed_reg;
        item_next      = item_reg;
        delta_next     = delta_reg;
        err_next       = err_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        r_next         = r_reg;
        val_next       = val_reg;
        pterm_next     = pterm_reg;
        sum_next       = sum_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    item_next  = item;
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                unique case (item_reg.opcode)
                    OP_TICK:
                    begin
                        if (step_reg != 4'sd0)
                        begin
                            if (ramp_hit)
                            begin
                                setpoint_next = target_reg;
                                step_next     = 4'sd0;
                                if (stop_pend_reg)
                                begin
                                    run_next = 1'b0;
                                end
                            end
                            else
                            begin
                                setpoint_next = ramp_sum[31:0];
                            end
                        end
                        delta_next    = item_reg.encoder_position - last_pos_reg;
                        last_pos_next = item_reg.encoder_position;
                        state_next    = S_SPD;
                    end
                    OP_SET_TARGET:
                    begin
                        target_next = target_clamp;
                        spin_next   = (item_reg.command_value > 32'sd0) ? DIR_FWD : DIR_REV;
                        state_next  = S_TGT;
                    end
                    OP_START:
                    begin
                        run_next       = 1'b1;
                        stop_pend_next = 1'b0;
                        state_next     = S_DONE;
                    end
                    OP_STOP:
                    begin
                        stop_pend_next = 1'b1;
                        target_next    = 32'sd0;
                        step_next      = (spin_reg == DIR_FWD) ? RAMP_DOWN : RAMP_UP;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_TGT:
            begin
                if (target_reg > setpoint_reg)
                begin
                    step_next = RAMP_UP;
                end
                else if (target_reg < setpoint_reg)
                begin
                    step_next = RAMP_DOWN;
                end
                state_next = S_DONE;
            end
            S_SPD:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                speed_next = speed_now;
                if (err_wide[32] != err_wide[31])
                begin
                    err_next = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else
                begin
                    err_next = err_wide[31:0];
                end
                state_next = S_DIF;
            end
            S_DIF:
            begin
                neg_next   = d_ab[48];
                mag_next   = d_ab[48] ? d_ba : d_ab;
                job_next   = JOB_FILT;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                state_next = S_MHI;
            end
            S_MHI:
            begin
                acc_next   = mul_prod[48:0] + (q24_mode ? ROUND_HALF : 49'd0);
                state_next = S_MFIN;
            end
            S_MFIN:
            begin
                if (q24_mode)
                begin
                    r_next = 65'(mul_prod[48:0]) + 65'(acc_reg[48:24]);
                end
                else
                begin
                    r_next = {mul_prod[40:0], 24'd0} + 65'(acc_reg);
                end
                state_next = S_MSGN;
            end
            S_MSGN:
            begin
                if (r_reg[64:63] != 2'b00)
                begin
                    val_next = neg_reg ? INT64_MIN : INT64_MAX;
                end
                else
                begin
                    val_next = neg_reg ? -$signed(r_reg[63:0]) : $signed(r_reg[63:0]);
                end
                case (job_reg)
                    JOB_FILT: state_next = S_FUPD;
                    JOB_DT:
                    begin
                        mag_next   = r_reg[48:0];
                        job_next   = JOB_INT;
                        state_next = S_MLO;
                    end
                    JOB_INT:  state_next = S_IADD;
                    JOB_P:    state_next = S_DABS;
                    JOB_D:    state_next = S_SUM1;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_FUPD:
            begin
                if (filt_sum > Q48_HI)
                begin
                    filt_next = 48'sh7FFF_FFFF_FFFF;
                end
                else if (filt_sum < Q48_LO)
                begin
                    filt_next = 48'sh8000_0000_0000;
                end
                else
                begin
                    filt_next = filt_sum[47:0];
                end
                state_next = S_FABS;
            end
            S_FABS:
            begin
                neg_next   = filt_reg[47];
                mag_next   = filt_abs;
                job_next   = JOB_DT;
                state_next = S_MLO;
            end
            S_IADD:
            begin
                integ_next = sat_add64(integ_reg, val_reg);
                neg_next   = filt_reg[47];
                mag_next   = filt_abs;
                job_next   = JOB_P;
                state_next = S_MLO;
            end
            S_DABS:
            begin
                pterm_next = val_reg;
                neg_next   = d_ab[48];
                mag_next   = d_ab[48] ? d_ba : d_ab;
                job_next   = JOB_D;
                state_next = S_MLO;
            end
            S_SUM1:
            begin
                sum_next   = sat_add64(pterm_reg, val_reg);
                state_next = S_SUM2;
            end
            S_SUM2:
            begin
                sum_next   = sat_add64(sum_reg, integ_reg);
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                if (sum_reg < 64'sd0)
                begin
                    rev_next = 1'b1;
                end
                else if (sum_reg != 64'sd0)
                begin
                    rev_next = 1'b0;
                end
                if (run_reg)
                begin
                    duty_next = duty_calc;
                    prev_next = filt_reg;
                end
                else
                begin
                    duty_next  = 16'd0;
                    prev_next  = 48'sd0;
                    integ_next = 64'sd0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_FILT;
            last_pos_reg  <= '0;
            setpoint_reg  <= '0;
            target_reg    <= '0;
            step_reg      <= '0;
            spin_reg      <= DIR_NONE;
            stop_pend_reg <= 1'b0;
            run_reg       <= 1'b0;
            filt_reg      <= '0;
            prev_reg      <= '0;
            integ_reg     <= '0;
            rev_reg       <= 1'b0;
            duty_reg      <= '0;
            speed_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            last_pos_reg  <= last_pos_next;
            setpoint_reg  <= setpoint_next;
            target_reg    <= target_next;
            step_reg      <= step_next;
            spin_reg      <= spin_next;
            stop_pend_reg <= stop_pend_next;
            run_reg       <= run_next;
            filt_reg      <= filt_next;
            prev_reg      <= prev_next;
            integ_reg     <= integ_next;
            rev_reg       <= rev_next;
            duty_reg      <= duty_next;
            speed_reg     <= speed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        delta_reg <= delta_next;
        err_reg   <= err_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        r_reg     <= r_next;
        val_reg   <= val_next;
        pterm_reg <= pterm_next;
        sum_reg   <= sum_next;
    end

    assign sts.idle = (state_reg == S_IDLE);
    assign sts.done = (state_reg == S_DONE);

    // The filter value is truncated towards zero when its fraction is dropped.
    assign res.pwm_duty       = duty_reg;
    assign res.reverse_dir    = rev_reg;
    assign res.filtered_error = filt_reg[47:16]
                              + 32'(filt_reg[47] && (filt_reg[15:0] != 16'd0));
    assign res.measured_speed = speed_reg;
    assign res.ramp_setpoint  = setpoint_reg;
    assign res.running        = run_reg;

endmodule

@@ src/motor_speed_pid_with_ramp.sv @@
// Top level of the DC motor speed controller with setpoint ramp and PID loop.
// Depends on msp_pkg, msp_if, msp_mul and msp_core.
//
// Items arrive on the request channel with an opcode: a control tick with
// the sampled encoder position, a target speed, start or stop. Every item
// gives exactly one result item on the response channel, carrying the PWM
// duty, direction, filtered error, measured speed, ramp setpoint and run flag.
// Gains are written through the cfg channel, which is always ready; writes
// are meant to happen while no item is in progress.
// A control tick passes through eleven products of the single shared
// multiplier before its result is valid; a start, stop or target command
// takes no product. The request channel is ready only while no item is in
// progress, so a new item is accepted only once the last one has finished
// and its result has been taken into the output register.
// The result is held in an output register; while the receiver stalls, the
// block still accepts the next item and finishes it, then waits with that
// result until the register is free.
// Reset clears the control state, the run flag and the integrator, and sets
// the gains to 32, 16 and 64.
module motor_speed_pid_with_ramp (
    input  logic      clk,
    input  logic      rst_n,
    msp_in_if.sink    request,
    msp_out_if.source response,
    msp_cfg_if.sink   cfg
);
    import msp_pkg::*;

    msp_gains_t    gains_reg, gains_next;
    msp_result_t   out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    msp_ctl_t      ctl;
    msp_sts_t      sts;
    msp_item_t     item;
    msp_result_t   res;
    msp_mul_req_t  mul_req;
    logic [MUL_P_W-1:0] mul_prod;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_PROP:  gains_next.prop_gain  = cfg.wdata;
                REG_INTEG: gains_next.integ_gain = cfg.wdata;
                REG_DERIV: gains_next.deriv_gain = cfg.wdata;
                default:   gains_next = gains_reg;
            endcase
        end
    end

    assign item.opcode           = request.opcode;
    assign item.encoder_position = request.encoder_position;
    assign item.command_value    = request.command_value;

    assign request.ready = sts.idle;
    assign ctl.start     = request.valid && sts.idle;
    assign ctl.take      = !out_valid_reg || response.ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (sts.done && ctl.take)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop_gain  <= 16'd32;
            gains_reg.integ_gain <= 16'd16;
            gains_reg.deriv_gain <= 16'd64;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            gains_reg     <= gains_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign response.valid          = out_valid_reg;
    assign response.pwm_duty       = out_reg.pwm_duty;
    assign response.reverse_dir    = out_reg.reverse_dir;
    assign response.filtered_error = out_reg.filtered_error;
    assign response.measured_speed = out_reg.measured_speed;
    assign response.ramp_setpoint  = out_reg.ramp_setpoint;
    assign response.running        = out_reg.running;

    msp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .item     (item),
        .gains    (gains_reg),
        .sts      (sts),
        .res      (res),
        .mul_req  (mul_req),
        .mul_prod (mul_prod)
    );

    msp_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

endmodule

@@ src/msp_checker.sv @@
// Port-level checks for the motor speed PID controller, bound to its top level.
// Depends on msp_pkg and on motor_speed_pid_with_ramp.
module msp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [15:0]        pwm_duty,
    input logic               reverse_dir,
    input logic signed [31:0] filtered_error,
    input logic signed [31:0] measured_speed,
    input logic signed [31:0] ramp_setpoint,
    input logic               running
);
    import msp_pkg::*;

    // Only one item is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while an item was still in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pwm_duty)
            && $stable(reverse_dir) && $stable(filtered_error)
            && $stable(measured_speed) && $stable(ramp_setpoint) && $stable(running))
        else $error("stalled result changed");

    // A stopped motor always reports zero duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> pwm_duty == 16'd0)
        else $error("non-zero duty while stopped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pwm_duty <= PWM_PERIOD)
        else $error("duty beyond the PWM period");

endmodule

bind motor_speed_pid_with_ramp msp_checker u_msp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (request.valid),
    .in_ready       (request.ready),
    .out_valid      (response.valid),
    .out_ready      (response.ready),
    .pwm_duty       (response.pwm_duty),
    .reverse_dir    (response.reverse_dir),
    .filtered_error (response.filtered_error),
    .measured_speed (response.measured_speed),
    .ramp_setpoint  (response.ramp_setpoint),
    .running        (response.running)
);

@@ sim/msp_speed_checker.sv @@
// Checker for the motor speed PID controller: watches the item, result and gain channels,
// predicts every result item from its own copy of the controller state and compares it.
// Depends on msp_pkg and the channel interfaces of msp_if.
module msp_speed_checker
    import msp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    msp_in_if    request,
    msp_out_if   response,
    msp_cfg_if   cfg,
    output int   outstanding,
    output int   mismatches
);

    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = -S64_MAX - 1;
    localparam longint Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint Q48_MIN = -Q48_MAX - 1;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -S32_MAX - 1;

    logic [15:0]        kp, ki, kd;
    logic [31:0]        last_pos;
    logic signed [31:0] setpoint, target;
    logic signed [3:0]  ramp_step;
    logic [1:0]         spin_dir;
    logic               stop_pend, run_flag, rev_latch;
    longint             filt_err, prev_filt, integ_sum;
    logic [15:0]        held_duty;
    logic signed [31:0] held_speed;
    msp_result_t        pending_results[$];

    function automatic logic [63:0] abs64(longint a);
        logic [63:0] m;
        m = a;
        if (a < 0)
        begin
            m = -m;
        end
        return m;
    endfunction

    function automatic longint sum_sat(longint a, longint b);
        if (b > 0 && a > S64_MAX - b)
        begin
            return S64_MAX;
        end
        if (b < 0 && a < S64_MIN - b)
        begin
            return S64_MIN;
        end
        return a + b;
    endfunction

    function automatic longint gain_mul(longint a, logic [15:0] k);
        logic [63:0] m;
        logic [63:0] r;
        m = abs64(a);
        if (k == 16'd0)
        begin
            return 0;
        end
        if (m > 64'h7FFF_FFFF_FFFF_FFFF / {48'd0, k})
        begin
            return (a < 0) ? S64_MIN : S64_MAX;
        end
        r = m * {48'd0, k};
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Product with a Q0.24 factor, rounded to nearest with ties away from zero.
    function automatic longint q24_round(longint a, logic [23:0] k);
        logic [63:0] m;
        logic [63:0] kk;
        logic [63:0] r;
        m  = abs64(a);
        kk = {40'd0, k};
        r  = (m >> 24) * kk + (((m & 64'h00FF_FFFF) * kk + 64'h0080_0000) >> 24);
        if (r > 64'h7FFF_FFFF_FFFF_FFFF)
        begin
            r = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp48(longint v);
        if (v > Q48_MAX)
        begin
            return Q48_MAX;
        end
        if (v < Q48_MIN)
        begin
            return Q48_MIN;
        end
        return v;
    endfunction

    function automatic void ramp_advance();
        longint s;
        if (ramp_step == 0)
        begin
            return;
        end
        s = longint'(setpoint) + ramp_step;
        if ((ramp_step > 0 && s >= target) || (ramp_step < 0 && s <= target))
        begin
            s = target;
            if (stop_pend)
            begin
                run_flag = 1'b0;
            end
            ramp_step = 4'sd0;
        end
        setpoint = s[31:0];
    endfunction

    function automatic void control_tick(logic [31:0] pos);
        logic signed [31:0] delta;
        longint             err, diff, p, d, out_sum;
        logic [63:0]        mag;
        delta      = pos - last_pos;
        last_pos   = pos;
        held_speed = delta * TICKS_PER_SEC;

        err = longint'(setpoint) - longint'(held_speed);
        if (err > S32_MAX)
        begin
            err = S32_MAX;
        end
        if (err < S32_MIN)
        begin
            err = S32_MIN;
        end

        diff      = err * 65536 - filt_err;
        filt_err  = clamp48(filt_err + q24_round(diff, FILT_K));
        p         = gain_mul(filt_err, kp);
        integ_sum = sum_sat(integ_sum, gain_mul(q24_round(filt_err, DT_K), ki));
        d         = gain_mul(filt_err - prev_filt, kd);
        prev_filt = filt_err;
        out_sum   = sum_sat(sum_sat(p, d), integ_sum);

        mag = 64'd0;
        if (out_sum < 0)
        begin
            rev_latch = 1'b1;
            mag = abs64(out_sum);
        end
        else if (out_sum > 0)
        begin
            rev_latch = 1'b0;
            mag = out_sum;
        end
        mag = mag >> 16;
        if (mag > {48'd0, PWM_PERIOD})
        begin
            mag = {48'd0, PWM_PERIOD};
        end
        held_duty = mag[15:0];

        if (!run_flag)
        begin
            held_duty = 16'd0;
            integ_sum = 0;
            prev_filt = 0;
        end
    endfunction

    function automatic void take_target(logic signed [31:0] raw);
        logic signed [31:0] t;
        t = raw;
        if (t > SPEED_LIMIT)
        begin
            t = SPEED_LIMIT;
        end
        if (t < -SPEED_LIMIT)
        begin
            t = -SPEED_LIMIT;
        end
        target   = t;
        spin_dir = (t > 0) ? DIR_FWD : DIR_REV;
        if (t > setpoint)
        begin
            ramp_step = RAMP_UP;
        end
        else if (t < setpoint)
        begin
            ramp_step = RAMP_DOWN;
        end
    endfunction

    function automatic msp_result_t next_controller_result(op_t op, logic [31:0] pos,
                                                           logic signed [31:0] cmd);
        msp_result_t r;
        case (op)
            OP_TICK:
            begin
                ramp_advance();
                control_tick(pos);
            end
            OP_SET_TARGET:
            begin
                take_target(cmd);
            end
            OP_START:
            begin
                run_flag  = 1'b1;
                stop_pend = 1'b0;
            end
            default:
            begin
                stop_pend = 1'b1;
                target    = 32'sd0;
                ramp_step = (spin_dir == DIR_FWD) ? RAMP_DOWN : RAMP_UP;
            end
        endcase
        r.pwm_duty       = held_duty;
        r.reverse_dir    = rev_latch;
        r.filtered_error = 32'(filt_err / 65536);
        r.measured_speed = held_speed;
        r.ramp_setpoint  = setpoint;
        r.running        = run_flag;
        return r;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        msp_result_t want;
        if (!rst_n)
        begin
            kp         = 16'd32;
            ki         = 16'd16;
            kd         = 16'd64;
            last_pos   = 32'd0;
            setpoint   = 32'sd0;
            target     = 32'sd0;
            ramp_step  = 4'sd0;
            spin_dir   = DIR_NONE;
            stop_pend  = 1'b0;
            run_flag   = 1'b0;
            rev_latch  = 1'b0;
            filt_err   = 0;
            prev_filt  = 0;
            integ_sum  = 0;
            held_duty  = 16'd0;
            held_speed = 32'sd0;
            mismatches = 0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (reg_idx_t'(cfg.reg_index))
                    REG_PROP:  kp = cfg.wdata;
                    REG_INTEG: ki = cfg.wdata;
                    REG_DERIV: kd = cfg.wdata;
                    default:   ;
                endcase
            end

            if (response.valid && response.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result item arrived with no item outstanding", $realtime);
                    end
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("pwm_duty", want.pwm_duty, response.pwm_duty);
                    check_field("reverse_dir", want.reverse_dir, response.reverse_dir);
                    check_field("filtered_error", signed'(want.filtered_error),
                                signed'(response.filtered_error));
                    check_field("measured_speed", signed'(want.measured_speed),
                                signed'(response.measured_speed));
                    check_field("ramp_setpoint", signed'(want.ramp_setpoint),
                                signed'(response.ramp_setpoint));
                    check_field("running", want.running, response.running);
                end
            end

            if (request.valid && request.ready)
            begin
                pending_results.push_back(next_controller_result(op_t'(request.opcode),
                                                                 request.encoder_position,
                                                                 request.command_value));
            end

            outstanding <= pending_results.size();
        end
    end

endmodule

@@ sim/motor_speed_pid_with_ramp_tb.sv @@
// Top of the regression for the motor speed PID controller with setpoint ramp.
// Drives directed and random items, gain writes and result stalls; msp_speed_checker judges.
// Depends on msp_pkg, msp_if, msp_speed_checker and the block itself.
module motor_speed_pid_with_ramp_tb;
    import msp_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        result_ready = 1'b0;
    int          outstanding;
    int          mismatches;
    int          burst_left;
    int          items_sent;
    int          stall_mode;
    int          stall_left;
    logic [31:0] enc_pos;

    msp_in_if  request_ch();
    msp_out_if result_ch();
    msp_cfg_if gain_ch();

    assign result_ch.ready = result_ready;

    motor_speed_pid_with_ramp i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request_ch),
        .response (result_ch),
        .cfg      (gain_ch)
    );

    msp_speed_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request_ch),
        .response    (result_ch),
        .cfg         (gain_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // The receiver switches between always ready, random stalls and long stalls.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(16, 120);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= ($urandom_range(0, 1) == 1);
            default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_item(op_t op, logic [31:0] pos, logic signed [31:0] cmd);
        if (burst_left == 0)
        begin
            request_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(1, 12);
        end
        request_ch.valid            <= 1'b1;
        request_ch.opcode           <= op;
        request_ch.encoder_position <= pos;
        request_ch.command_value    <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!request_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic tick_by(logic [31:0] delta);
        enc_pos = enc_pos + delta;
        send_item(OP_TICK, enc_pos, $urandom);
    endtask

    task automatic wait_idle();
        request_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_gain(logic [1:0] index, logic [15:0] value);
        gain_ch.valid     <= 1'b1;
        gain_ch.reg_index <= index;
        gain_ch.wdata     <= value;
        do
        begin
            @(posedge clk);
        end
        while (!gain_ch.ready);
    endtask

    task automatic set_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d, bit spare);
        wait_idle();
        write_gain(REG_PROP, p);
        write_gain(REG_INTEG, i);
        write_gain(REG_DERIV, d);
        if (spare)
        begin
            write_gain(REG_SPARE, 16'($urandom));
        end
        gain_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 40) - 20;
            6, 7:             return $urandom_range(0, 4000) - 2000;
            8:                return 32'd2147484;
            9:                return -32'd2147483;
            10:               return ($urandom_range(0, 1) == 1) ? 32'd2147483 : -32'd2147484;
            default:          return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_target();
        int mag;
        mag = $urandom_range(0, 24000);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'd0;
            default: return ($urandom_range(0, 1) == 1) ? -mag : mag;
        endcase
    endfunction

    task automatic run_random(int upto);
        int n_ticks;
        while (items_sent < upto)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                send_item(OP_SET_TARGET, $urandom, pick_target());
                if ($urandom_range(0, 4) != 0)
                begin
                    send_item(OP_START, $urandom, $urandom);
                end
                n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(5, 30);
                if (n_ticks > upto - items_sent)
                begin
                    n_ticks = (upto > items_sent) ? upto - items_sent : 0;
                end
                repeat (n_ticks) tick_by(pick_delta());
                if ($urandom_range(0, 2) == 0)
                begin
                    send_item(OP_STOP, $urandom, $urandom);
                    repeat ($urandom_range(3, 20)) tick_by(pick_delta());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        enc_pos = $urandom;
                    end
                    send_item(op_t'($urandom_range(0, 3)), enc_pos, $urandom);
                end
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        burst_left = 0;
        items_sent = 0;
        enc_pos    = 32'd0;
        request_ch.valid            <= 1'b0;
        request_ch.opcode           <= OP_TICK;
        request_ch.encoder_position <= 32'd0;
        request_ch.command_value    <= 32'sd0;
        gain_ch.valid               <= 1'b0;
        gain_ch.reg_index           <= REG_PROP;
        gain_ch.wdata               <= 16'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the gains as left by reset.
        tick_by(32'd0);
        tick_by(32'hFFFF_FFFF);
        send_item(OP_STOP, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
        tick_by(32'd0);
        send_item(OP_START, 32'd0, 32'sh8000_0000);
        send_item(OP_SET_TARGET, 32'hFFFF_FFFF, 32'sd0);
        send_item(OP_SET_TARGET, 32'd0, 32'sh7FFF_FFFF);
        tick_by(32'd0);
        tick_by(32'd3);
        tick_by(32'hFFFF_FFF0);
        tick_by(32'd2147483);
        send_item(OP_SET_TARGET, 32'hA5A5_A5A5, 32'sh8000_0000);
        tick_by(32'd2147484);
        tick_by(-32'd2147484);
        send_item(OP_SET_TARGET, 32'h5A5A_5A5A, 32'sd1);
        tick_by(32'h8000_0000);
        tick_by(32'd0);
        send_item(OP_STOP, 32'd0, 32'sd0);
        repeat (7) tick_by(32'd0);

        set_gains(16'd0, 16'd0, 16'd0, 1'b1);
        run_random(items_sent + 100);
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_random(items_sent + 100);
        set_gains(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        run_random(items_sent + 100);
        set_gains(16'd1, 16'd0, 16'hFFFF, 1'b0);
        run_random(items_sent + 100);
        set_gains(16'd32, 16'd16, 16'd64, 1'b0);
        run_random(items_sent + 100);

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("motor_speed_pid_with_ramp regression: pass");
        end
        else
        begin
            $display("motor_speed_pid_with_ramp regression: fail");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("motor_speed_pid_with_ramp regression: fail");
        $finish;
    end

endmodule
